@@ rtl/ryc_pkg.sv @@
`timescale 1ns / 1ps
// ryc_pkg: widths, default precision and conversion weights of the rgb to ycbcr block
// no dependencies; taken in by the channel interfaces and the top level

package ryc_pkg;

  localparam int PIXEL_W           = 8;
  localparam int FRAC_BITS_DEFAULT = 2;

  // jpeg weights in units of 1/10000
  localparam int WE4_Y_R  = 2990;
  localparam int WE4_Y_G  = 5870;
  localparam int WE4_Y_B  = 1140;
  localparam int WE4_CB_R = 1687;
  localparam int WE4_CB_G = 3313;
  localparam int WE4_CB_B = 5000;
  localparam int WE4_CR_R = 5000;
  localparam int WE4_CR_G = 4187;
  localparam int WE4_CR_B = 813;
  localparam int WE4_ONE  = 10000;

  localparam int CHROMA_OFFSET = 128;
  localparam int PIXEL_MAX     = 255;

endpackage

@@ rtl/ryc_rgb_if.sv @@
`timescale 1ns / 1ps
// ryc_rgb_if: valid/ready channel carrying one rgb pixel
// depends on ryc_pkg

interface ryc_rgb_if import ryc_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] red;
  logic [PIXEL_W-1:0] green;
  logic [PIXEL_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

@@ rtl/ryc_ycc_if.sv @@
`timescale 1ns / 1ps
// ryc_ycc_if: valid/ready channel carrying one y, cb, cr pixel
// depends on ryc_pkg

interface ryc_ycc_if import ryc_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] luma;
  logic [PIXEL_W-1:0] chroma_blue;
  logic [PIXEL_W-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);

endinterface

@@ rtl/rgb_to_ycbcr_fixed_point.sv @@
`timescale 1ns / 1ps
// rgb_to_ycbcr_fixed_point: four-stage pipelined jpeg rgb to ycbcr converter
// depends on ryc_pkg, ryc_rgb_if and ryc_ycc_if

// Converts one 8-bit RGB pixel per clock, while the output does not stall, into
// full-range Y, Cb, Cr. The nine weights are rounded to FRAC_BITS fractional
// bits at elaboration; each weighted sum is divided by 2^FRAC_BITS truncating
// toward zero, chroma gets +128 and every channel saturates to 0..255. There
// are four register stages (products, sums, scaling with offset, saturation),
// and a new pixel is taken every cycle while the output does not stall. Each
// stage holds only while it is full and the stage after it cannot move, so a
// stall on the output fills bubbles before the input is held.

module rgb_to_ycbcr_fixed_point import ryc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  ryc_rgb_if.sink  rgb,
  ryc_ycc_if.source ycbcr
);

  localparam int WW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + PIXEL_W;
  localparam int SW = FRAC_BITS + PIXEL_W + 3;
  localparam int QW = SW - FRAC_BITS;

  localparam int HALF = WE4_ONE / 2;

  localparam int WI_Y_R  = ((WE4_Y_R  << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_Y_G  = ((WE4_Y_G  << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_Y_B  = ((WE4_Y_B  << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CB_R = ((WE4_CB_R << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CB_G = ((WE4_CB_G << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CB_B = ((WE4_CB_B << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CR_R = ((WE4_CR_R << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CR_G = ((WE4_CR_G << FRAC_BITS) + HALF) / WE4_ONE;
  localparam int WI_CR_B = ((WE4_CR_B << FRAC_BITS) + HALF) / WE4_ONE;

  localparam logic [WW-1:0] W_Y_R  = WW'(WI_Y_R);
  localparam logic [WW-1:0] W_Y_G  = WW'(WI_Y_G);
  localparam logic [WW-1:0] W_Y_B  = WW'(WI_Y_B);
  localparam logic [WW-1:0] W_CB_R = WW'(WI_CB_R);
  localparam logic [WW-1:0] W_CB_G = WW'(WI_CB_G);
  localparam logic [WW-1:0] W_CB_B = WW'(WI_CB_B);
  localparam logic [WW-1:0] W_CR_R = WW'(WI_CR_R);
  localparam logic [WW-1:0] W_CR_G = WW'(WI_CR_G);
  localparam logic [WW-1:0] W_CR_B = WW'(WI_CR_B);

  localparam logic signed [QW-1:0] Q_OFFSET = QW'(CHROMA_OFFSET);
  localparam logic signed [QW-1:0] Q_MAX    = QW'(PIXEL_MAX);

  typedef logic [PW-1:0]        prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [QW-1:0] quot_t;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  prod_t p_y_r, p_y_g, p_y_b;
  prod_t p_cb_r, p_cb_g, p_cb_b;
  prod_t p_cr_r, p_cr_g, p_cr_b;

  sum_t s_y, s_cb, s_cr;
  sum_t s_y_next, s_cb_next, s_cr_next;

  quot_t q_y, q_cb, q_cr;
  quot_t q_y_next, q_cb_next, q_cr_next;

  logic [PIXEL_W-1:0] o_y, o_cb, o_cr;

  // stage handshake
  assign adv4 = !v4 || ycbcr.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign rgb.ready         = adv1;
  assign ycbcr.valid       = v4;
  assign ycbcr.luma        = o_y;
  assign ycbcr.chroma_blue = o_cb;
  assign ycbcr.chroma_red  = o_cr;

  function automatic prod_t mul_w(input logic [PIXEL_W-1:0] pix, input logic [WW-1:0] w);
    return PW'(PW'(pix) * PW'(w));
  endfunction

  function automatic sum_t ext(input prod_t p);
    return signed'(SW'(p));
  endfunction

  // divide by 2^FRAC_BITS toward zero
  function automatic quot_t scale(input sum_t s, input quot_t offs);
    quot_t fl;
    logic  corr;
    fl   = QW'(s >>> FRAC_BITS);
    corr = s[SW-1] && (|s[FRAC_BITS-1:0]);
    return fl + offs + QW'({1'b0, corr});
  endfunction

  function automatic logic [PIXEL_W-1:0] sat(input quot_t q);
    logic [PIXEL_W-1:0] r;
    if (q < 0) begin
      r = '0;
    end else if (q > Q_MAX) begin
      r = PIXEL_W'(PIXEL_MAX);
    end else begin
      r = q[PIXEL_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    s_y_next  = ext(p_y_r) + ext(p_y_g) + ext(p_y_b);
    s_cb_next = ext(p_cb_b) - ext(p_cb_r) - ext(p_cb_g);
    s_cr_next = ext(p_cr_r) - ext(p_cr_g) - ext(p_cr_b);
    q_y_next  = scale(s_y, '0);
    q_cb_next = scale(s_cb, Q_OFFSET);
    q_cr_next = scale(s_cr, Q_OFFSET);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= rgb.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      p_y_r  <= mul_w(rgb.red,   W_Y_R);
      p_y_g  <= mul_w(rgb.green, W_Y_G);
      p_y_b  <= mul_w(rgb.blue,  W_Y_B);
      p_cb_r <= mul_w(rgb.red,   W_CB_R);
      p_cb_g <= mul_w(rgb.green, W_CB_G);
      p_cb_b <= mul_w(rgb.blue,  W_CB_B);
      p_cr_r <= mul_w(rgb.red,   W_CR_R);
      p_cr_g <= mul_w(rgb.green, W_CR_G);
      p_cr_b <= mul_w(rgb.blue,  W_CR_B);
    end
    if (adv2) begin
      s_y  <= s_y_next;
      s_cb <= s_cb_next;
      s_cr <= s_cr_next;
    end
    if (adv3) begin
      q_y  <= q_y_next;
      q_cb <= q_cb_next;
      q_cr <= q_cr_next;
    end
    if (adv4) begin
      o_y  <= sat(q_y);
      o_cb <= sat(q_cb);
      o_cr <= sat(q_cr);
    end
  end

endmodule

@@ tb/sv/ycc_compare.sv @@
`timescale 1ns / 1ps
// ycc_compare: watches the rgb and ycbcr channels, works out the expected pixel
// for every rgb transfer and compares it with the results; depends on ryc_pkg and both channel interfaces

module ycc_compare import ryc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  ryc_rgb_if   rgb,
  ryc_ycc_if   ycbcr,
  output int   mismatches,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic [PIXEL_W-1:0] luma;
    logic [PIXEL_W-1:0] chroma_blue;
    logic [PIXEL_W-1:0] chroma_red;
  } ycc_pix_t;

  // weights rounded to nearest, ties up
  localparam longint W_Y_R  = ((longint'(WE4_Y_R)  << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_Y_G  = ((longint'(WE4_Y_G)  << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_Y_B  = ((longint'(WE4_Y_B)  << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CB_R = ((longint'(WE4_CB_R) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CB_G = ((longint'(WE4_CB_G) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CB_B = ((longint'(WE4_CB_B) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CR_R = ((longint'(WE4_CR_R) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CR_G = ((longint'(WE4_CR_G) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint W_CR_B = ((longint'(WE4_CR_B) << FRAC_BITS) + WE4_ONE / 2) / WE4_ONE;
  localparam longint SCALE  = longint'(1) << FRAC_BITS;

  ycc_pix_t pending_ycc[$];

  // signed division truncates toward zero, then clip to a byte
  function automatic logic [PIXEL_W-1:0] scale_clip(input longint sum, input longint offset);
    longint v;
    v = sum / SCALE + offset;
    if (v < 0) return '0;
    if (v > PIXEL_MAX) return PIXEL_W'(PIXEL_MAX);
    return PIXEL_W'(v);
  endfunction

  function automatic ycc_pix_t convert_pixel(input logic [PIXEL_W-1:0] r,
                                             input logic [PIXEL_W-1:0] g,
                                             input logic [PIXEL_W-1:0] b);
    longint rs, gs, bs;
    ycc_pix_t p;
    rs = longint'(r);
    gs = longint'(g);
    bs = longint'(b);
    p.luma        = scale_clip(W_Y_R * rs + W_Y_G * gs + W_Y_B * bs, 0);
    p.chroma_blue = scale_clip(-W_CB_R * rs - W_CB_G * gs + W_CB_B * bs, CHROMA_OFFSET);
    p.chroma_red  = scale_clip(W_CR_R * rs - W_CR_G * gs - W_CR_B * bs, CHROMA_OFFSET);
    return p;
  endfunction

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    ycc_pix_t want;
    if (!rst) begin
      if (rgb.valid && rgb.ready)
        pending_ycc.push_back(convert_pixel(rgb.red, rgb.green, rgb.blue));
      if (ycbcr.valid && ycbcr.ready) begin
        results_seen <= results_seen + 1;
        if (pending_ycc.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: Y %0d Cb %0d Cr %0d with no pixel pending",
                     results_seen, ycbcr.luma, ycbcr.chroma_blue, ycbcr.chroma_red);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_ycc.pop_front();
          if (want.luma !== ycbcr.luma || want.chroma_blue !== ycbcr.chroma_blue ||
              want.chroma_red !== ycbcr.chroma_red) begin
            if (mismatches < 10)
              $display("result %0d: expected Y %0d Cb %0d Cr %0d, got Y %0d Cb %0d Cr %0d",
                       results_seen, want.luma, want.chroma_blue, want.chroma_red,
                       ycbcr.luma, ycbcr.chroma_blue, ycbcr.chroma_red);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= pending_ycc.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus, flow control and verdict for rgb_to_ycbcr_fixed_point
// depends on ryc_pkg, the channel interfaces, the block and ycc_compare

module tb;
  import ryc_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEFAULT;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;

  localparam logic [23:0] CORNERS [18] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF,
    24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE,
    24'h010204, 24'h081020, 24'h408001, 24'h020480, 24'hFF80FF, 24'h00FF80
  };

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_long;
  int   sent;
  int   idle_cycles;
  int   mismatches;
  int   pending;
  int   results_seen;

  ryc_rgb_if rgb_ch ();
  ryc_ycc_if ycc_ch ();

  rgb_to_ycbcr_fixed_point #(.FRAC_BITS(FRAC)) dut (
    .clk   (clk),
    .rst   (rst),
    .rgb   (rgb_ch),
    .ycbcr (ycc_ch)
  );

  ycc_compare #(.FRAC_BITS(FRAC)) compare (
    .clk          (clk),
    .rst          (rst),
    .rgb          (rgb_ch),
    .ycbcr        (ycc_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIXEL_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] g,
                            input logic [PIXEL_W-1:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      rgb_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rgb_ch.valid <= 1'b1;
    rgb_ch.red   <= r;
    rgb_ch.green <= g;
    rgb_ch.blue  <= b;
    do @(posedge clk); while (!rgb_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  // receiver side
  initial begin
    int stall;
    ycc_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        ycc_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 1'b0;
      end else if (no_idle) begin
        ycc_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          ycc_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        ycc_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (rgb_ch.valid && rgb_ch.ready) || (ycc_ch.valid && ycc_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst          = 1'b1;
    no_idle      = 1'b0;
    hold_long    = 1'b0;
    sent         = 0;
    idle_cycles  = 0;
    rgb_ch.valid = 1'b0;
    rgb_ch.red   = '0;
    rgb_ch.green = '0;
    rgb_ch.blue  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (CORNERS[i])
      send_pixel(CORNERS[i][23:16], CORNERS[i][15:8], CORNERS[i][7:0]);
    send_random(650);

    // let the pipeline empty
    rgb_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    no_idle = 1'b1;
    send_random(300);

    // output held off while the input keeps offering
    hold_long = 1'b1;
    send_random(60);
    no_idle = 1'b0;

    rgb_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    send_random(620);

    rgb_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("%0d pixels sent: corner and walking-bit pixels, random pixels with gaps,", sent);
    $display("a back-to-back burst, a long output hold-off and drains; %0d results checked",
             results_seen);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
